FILE: rtl/core/assert_macros.svh
// Assertion helpers; each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication.
`define CHK_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/cfvg_pkg.sv
package cfvg_pkg;

  localparam logic [31:0] FIVE_Q16 = 32'd327680;
  localparam logic [20:0] RECIP_11 = 21'd1525201;  // floor(2^24 / 11)
  localparam logic [7:0]  SEG_BASE = 8'd18;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] radius;
    logic [7:0]         vertex_number;
  } item_t;

  typedef struct packed {
    item_t      it;
    logic [7:0] count;
  } cnt_item_t;

  typedef struct packed {
    item_t      it;
    logic [7:0] count;
    logic       in_range;
    logic       has_triangle;
    logic [7:0] tri_third;
  } ctl_t;

  // Shift-subtract quotient, used only to build constant tables.
  function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

FILE: rtl/core/circle_fan_vertex_generator.sv
// Circle fan vertex generator.
// Slave stream: one circle (center, signed radius, Q16.16) plus a vertex
// number per transfer. Master stream: segment count, vertex position and
// the fan triangle (i, 0, i+1, wrapping to 1) starting at that vertex;
// tuser carries in_range and has_triangle.
// Throughput: one item per cycle unless the receiver stalls; the nine
// stages are count (3), phase division (3) and sine lookup / multiply /
// saturate (3). The phase divide uses a reciprocal table indexed by
// segment count, the trig values come from registered sine and cosine
// ROMs of SINE_TABLE_ENTRIES words.
// Reset clears all stage valid bits; no item is in flight afterward.
// When the receiver stalls (m_tready low with m_tvalid high) the whole
// pipeline freezes and s_tready drops in the same cycle; nothing is lost
// or repeated. Bubbles are carried through, not squeezed out.
module circle_fan_vertex_generator #(
  parameter int MAX_SEGMENTS       = 255,
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,  // center_x, center_y, radius, vertex_number
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,  // segment_count, vertex_x, vertex_y, tri_first,
                                 // tri_second, tri_third
  output logic [1:0]   m_tuser   // in_range, has_triangle
);
  import cfvg_pkg::*;

  localparam int AW = $clog2(SINE_TABLE_ENTRIES);

  logic               en;
  item_t              in_item;
  logic               cv, pv;
  cnt_item_t          citem;
  ctl_t               pctl, octl;
  logic [AW-1:0]      phase;
  logic signed [31:0] vx, vy;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  assign in_item.center_x      = s_tdata[31:0];
  assign in_item.center_y      = s_tdata[63:32];
  assign in_item.radius        = s_tdata[95:64];
  assign in_item.vertex_number = s_tdata[103:96];

  cfvg_count #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_count (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid), .in_item(in_item),
    .out_valid(cv), .out_item(citem)
  );

  cfvg_phase #(.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)) u_phase (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(cv), .in_item(citem),
    .out_valid(pv), .out_ctl(pctl), .phase(phase)
  );

  cfvg_pos #(.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)) u_pos (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(pv), .in_ctl(pctl), .phase(phase),
    .out_valid(m_tvalid), .out_ctl(octl),
    .vertex_x(vx), .vertex_y(vy)
  );

  assign m_tdata = {
    octl.has_triangle ? octl.tri_third : 8'd0,
    8'd0,
    octl.has_triangle ? octl.it.vertex_number : 8'd0,
    vy,
    vx,
    octl.count
  };
  assign m_tuser = {octl.has_triangle, octl.in_range};

endmodule

FILE: rtl/core/cfvg_count.sv
module cfvg_count #(
  parameter int MAX_SEGMENTS = 255
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  cfvg_pkg::item_t   in_item,
  output logic              out_valid,
  output cfvg_pkg::cnt_item_t out_item
);
  import cfvg_pkg::*;

  logic [31:0] mag;
  logic [32:0] diff;
  logic [34:0] diff5;
  logic [4:0]  small_base;

  logic        v1, v2, v3;
  item_t       it1, it2;
  logic        small1, small2;
  logic [7:0]  scnt1, scnt2;
  logic [18:0] u1, u2;
  logic [15:0] qa2;

  logic [39:0] qprod;
  logic [19:0] q11;
  logic [18:0] rem;
  logic [15:0] q;
  logic [16:0] big;
  logic [7:0]  count;

  assign mag        = in_item.radius[31] ? (~in_item.radius + 32'd1) : in_item.radius;
  assign diff       = {1'b0, mag} - {1'b0, FIVE_Q16};
  assign diff5      = {diff, 2'b00} + {2'b00, diff};
  assign small_base = {2'b00, mag[18:16]} + 5'd3;
  assign qprod      = {21'd0, u1} * {19'd0, RECIP_11};

  assign q11   = {1'b0, qa2, 3'b000} + {3'b000, qa2, 1'b0} + {4'd0, qa2};
  assign rem   = u2 - q11[18:0];
  assign q     = qa2 + ((rem >= 19'd11) ? 16'd1 : 16'd0);
  assign big   = {1'b0, q} + {9'd0, SEG_BASE};
  assign count = small2 ? scnt2 :
                 (big > 17'(MAX_SEGMENTS)) ? 8'(MAX_SEGMENTS) : big[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1    <= in_item;
      small1 <= (mag <= FIVE_Q16);
      scnt1  <= {2'b00, small_base, 1'b0};
      u1     <= diff5[34:16];
      it2    <= it1;
      small2 <= small1;
      scnt2  <= scnt1;
      u2     <= u1;
      qa2    <= qprod[39:24];
      out_item.it    <= it2;
      out_item.count <= count;
    end
  end

  assign out_valid = v3;

endmodule

FILE: rtl/core/cfvg_phase.sv
module cfvg_phase #(
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  cfvg_pkg::cnt_item_t               in_item,
  output logic                              out_valid,
  output cfvg_pkg::ctl_t                    out_ctl,
  output logic [$clog2(SINE_TABLE_ENTRIES)-1:0] phase
);
  import cfvg_pkg::*;

  localparam int AW    = $clog2(SINE_TABLE_ENTRIES);
  localparam int PW    = AW + 1;
  localparam int NUM_W = AW + 8;

  typedef logic [29:0] rtab_t [256];

  function automatic rtab_t build_recip();
    rtab_t t;
    longint unsigned one;
    one = 64'd1 << 32;
    for (int i = 0; i < 256; i++) begin
      t[i] = (i < 6) ? 30'd0 : 30'(udiv64(one, 64'(i)));
    end
    return t;
  endfunction

  localparam rtab_t RECIP_TAB = build_recip();

  logic             v4, v5, v6;
  cnt_item_t        c4, c5;
  logic [NUM_W-1:0] num4, num5;
  logic [29:0]      rc4;
  logic [PW-1:0]    pa5;

  logic [7:0]          vm1;
  logic [NUM_W-1:0]    num;
  logic [NUM_W+29:0]   prod;
  logic [NUM_W+7:0]    back;
  logic [NUM_W-1:0]    rem;
  logic [PW-1:0]       qc;
  logic [PW-1:0]       qm;
  logic                inr;
  logic                has_tri;

  assign vm1  = in_item.it.vertex_number - 8'd1;
  assign num  = NUM_W'(vm1) * NUM_W'(SINE_TABLE_ENTRIES) + NUM_W'(in_item.count[7:1]);
  assign prod = {30'd0, num4} * {{NUM_W{1'b0}}, rc4};
  assign back = (NUM_W+8)'(pa5) * (NUM_W+8)'(c5.count);
  assign rem  = num5 - back[NUM_W-1:0];
  assign qc   = pa5 + ((rem >= NUM_W'(c5.count)) ? PW'(1) : PW'(0));
  assign qm   = (qc >= PW'(SINE_TABLE_ENTRIES)) ? qc - PW'(SINE_TABLE_ENTRIES) : qc;
  assign inr  = (c5.it.vertex_number == 8'd0) || (c5.it.vertex_number <= c5.count);
  assign has_tri = (c5.it.vertex_number != 8'd0) && (c5.it.vertex_number <= c5.count);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v4 <= in_valid;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4   <= in_item;
      num4 <= num;
      rc4  <= RECIP_TAB[in_item.count];
      c5   <= c4;
      num5 <= num4;
      pa5  <= prod[32 +: PW];
      out_ctl.it           <= c5.it;
      out_ctl.count        <= c5.count;
      out_ctl.in_range     <= inr;
      out_ctl.has_triangle <= has_tri;
      out_ctl.tri_third    <= (c5.it.vertex_number == c5.count) ? 8'd1
                                                                : c5.it.vertex_number + 8'd1;
      phase <= qm[AW-1:0];
    end
  end

  assign out_valid = v6;

endmodule

FILE: rtl/core/cfvg_pos.sv
module cfvg_pos #(
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  cfvg_pkg::ctl_t                        in_ctl,
  input  logic [$clog2(SINE_TABLE_ENTRIES)-1:0] phase,
  output logic                                  out_valid,
  output cfvg_pkg::ctl_t                        out_ctl,
  output logic signed [31:0]                    vertex_x,
  output logic signed [31:0]                    vertex_y
);
  import cfvg_pkg::*;

  localparam longint unsigned N       = longint'(SINE_TABLE_ENTRIES);
  localparam longint unsigned HALF_PI = 64'd1686629713;

  typedef logic signed [15:0] stab_t [SINE_TABLE_ENTRIES];

  function automatic logic signed [15:0] quarter_sine(longint unsigned a);
    longint unsigned mag;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned q;
    longint          sum;
    logic            neg;
    if (a <= N) begin
      mag = a; neg = 1'b0;
    end else if (a <= 2 * N) begin
      mag = 2 * N - a; neg = 1'b0;
    end else if (a <= 3 * N) begin
      mag = a - 2 * N; neg = 1'b1;
    end else begin
      mag = 4 * N - a; neg = 1'b1;
    end
    x    = udiv64(mag * HALF_PI, N);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 5; k++) begin
      term = udiv64((term * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    q = (longint'(sum) + 16384) >> 15;
    if (q > 32767) q = 32767;
    return neg ? -16'(q) : 16'(q);
  endfunction

  function automatic stab_t build_sin();
    stab_t t;
    for (int p = 0; p < SINE_TABLE_ENTRIES; p++) t[p] = quarter_sine(4 * longint'(p));
    return t;
  endfunction

  function automatic stab_t build_cos();
    stab_t t;
    for (int p = 0; p < SINE_TABLE_ENTRIES; p++)
      t[p] = quarter_sine((4 * longint'(p) + N) % (4 * N));
    return t;
  endfunction

  localparam stab_t SIN_TAB = build_sin();
  localparam stab_t COS_TAB = build_cos();

  logic               v7, v8, v9;
  ctl_t               k7, k8;
  logic signed [15:0] sin7, cos7;
  logic signed [47:0] px8, py8;

  logic signed [47:0] rx, ry;
  logic signed [32:0] offx, offy;
  logic signed [33:0] sx, sy;
  logic signed [31:0] satx, saty;

  assign rx   = px8 + 48'sd16384;
  assign ry   = py8 + 48'sd16384;
  assign offx = rx[47:15];
  assign offy = ry[47:15];
  assign sx   = 34'(k8.it.center_x) + 34'(offx);
  assign sy   = 34'(k8.it.center_y) - 34'(offy);
  assign satx = (sx > 34'sd2147483647) ? 32'sh7fffffff :
                (sx < -34'sd2147483648) ? 32'sh80000000 : sx[31:0];
  assign saty = (sy > 34'sd2147483647) ? 32'sh7fffffff :
                (sy < -34'sd2147483648) ? 32'sh80000000 : sy[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else if (en) begin
      v7 <= in_valid;
      v8 <= v7;
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k7   <= in_ctl;
      sin7 <= SIN_TAB[phase];
      cos7 <= COS_TAB[phase];
      k8   <= k7;
      px8  <= 48'(k7.it.radius) * 48'(cos7);
      py8  <= 48'(k7.it.radius) * 48'(sin7);
      out_ctl <= k8;
      if (k8.has_triangle) begin
        vertex_x <= satx;
        vertex_y <= saty;
      end else if (k8.in_range) begin
        vertex_x <= k8.it.center_x;
        vertex_y <= k8.it.center_y;
      end else begin
        vertex_x <= '0;
        vertex_y <= '0;
      end
    end
  end

  assign out_valid = v9;

endmodule

FILE: rtl/core/cfvg_checker.sv
`include "assert_macros.svh"

module cfvg_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [95:0]  m_tdata,
  input logic [1:0]   m_tuser
);

  logic [7:0] t1, t2, t3;

  assign t1 = m_tdata[79:72];
  assign t2 = m_tdata[87:80];
  assign t3 = m_tdata[95:88];

  `CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  `CHK_NOW(a_tri_in_range, m_tvalid && m_tuser[1], m_tuser[0])
  `CHK_NOW(a_tri_shape, m_tvalid && m_tuser[1], (t2 == 8'd0) && (t1 != 8'd0) && ((t3 == t1 + 8'd1) || (t3 == 8'd1)))
  `CHK_NOW(a_out_of_range_zero, m_tvalid && !m_tuser[0], (m_tdata[71:8] == 64'd0) && !m_tuser[1])
  `CHK_NOW(a_count_min, m_tvalid, m_tdata[7:0] >= 8'd6)

endmodule

bind circle_fan_vertex_generator cfvg_checker u_cfvg_checker (
  .clk(clk), .rst(rst),
  .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser)
);

FILE: dv/tb_circle_fan_vertex_generator.sv
`timescale 1ns / 100ps

module tb_circle_fan_vertex_generator;
  import cfvg_pkg::*;

  localparam int TABLE_N = 1024;
  localparam int SEG_MAX = 255;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [7:0]         count;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               in_range;
    logic               has_tri;
    logic [7:0]         t1;
    logic [7:0]         t2;
    logic [7:0]         t3;
  } vertex_t;

  typedef struct {
    item_t   it;
    bit      typed;
    vertex_t want;
  } dir_row_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [103:0] s_tdata;  // center_x, center_y, radius, vertex_number
  logic         m_tvalid;
  logic         m_tready;
  logic [95:0]  m_tdata;  // segment_count, vertex_x, vertex_y, tri_first, tri_second, tri_third
  logic [1:0]   m_tuser;  // in_range, has_triangle

  vertex_t vertex_queue[$];
  int      errors;
  int      idle_pct;
  int      stall_pct;
  int      hold_cycles;

  circle_fan_vertex_generator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic int sine_q15(u64_t a);
    u64_t n, mag, x, x2, term, q;
    longint sum;
    bit neg;
    n = TABLE_N;
    if (a <= n) begin
      mag = a; neg = 0;
    end else if (a <= 2 * n) begin
      mag = 2 * n - a; neg = 0;
    end else if (a <= 3 * n) begin
      mag = a - 2 * n; neg = 1;
    end else begin
      mag = 4 * n - a; neg = 1;
    end
    x = (mag * 64'd1686629713) / n;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 5; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    q = (u64_t'(sum) + 16384) >> 15;
    if (q > 32767) q = 32767;
    return neg ? -int'(q) : int'(q);
  endfunction

  function automatic int rim_count(logic signed [31:0] r);
    u64_t m;
    u64_t c;
    m = (r < 0) ? u64_t'(-longint'(r)) : u64_t'(longint'(r));
    if (m <= 327680) c = ((m >> 16) + 3) * 2;
    else begin
      c = 18 + ((m - 327680) * 5) / (11 * 65536);
      if (c > SEG_MAX) c = SEG_MAX;
    end
    return int'(c);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic vertex_t predict_vertex(item_t it);
    vertex_t o;
    int cnt, s, c;
    u64_t p;
    longint r;
    cnt = rim_count(it.radius);
    r = longint'(it.radius);
    o = '0;
    o.count = cnt[7:0];
    if (it.vertex_number == 0) begin
      o.vx = it.center_x;
      o.vy = it.center_y;
      o.in_range = 1'b1;
    end else if (it.vertex_number <= cnt) begin
      p = ((u64_t'(it.vertex_number - 1) * TABLE_N + cnt / 2) / cnt) % TABLE_N;
      s = sine_q15(4 * p);
      c = sine_q15((4 * p + TABLE_N) % (4 * TABLE_N));
      o.vx = 32'(sat32(longint'(it.center_x) + ((r * c + 16384) >>> 15)));
      o.vy = 32'(sat32(longint'(it.center_y) - ((r * s + 16384) >>> 15)));
      o.in_range = 1'b1;
      o.has_tri = 1'b1;
      o.t1 = it.vertex_number;
      o.t3 = (it.vertex_number == cnt) ? 8'd1 : it.vertex_number + 8'd1;
    end
    return o;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    errors++;
  endtask

  task automatic send_circle(item_t it, bit typed, vertex_t want);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {it.vertex_number, it.radius, it.center_y, it.center_x};
    do @(posedge clk); while (!s_tready);
    vertex_queue.push_back(typed ? want : predict_vertex(it));
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    vertex_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[7:0], m_tdata[39:8], m_tdata[71:40], m_tuser[0], m_tuser[1],
             m_tdata[79:72], m_tdata[87:80], m_tdata[95:88]};
      if (vertex_queue.size() == 0) begin
        $display("unexpected output transfer");
        errors++;
      end else begin
        want = vertex_queue.pop_front();
        if (got.count != want.count) report_mismatch("segment_count", got.count, want.count);
        if (got.vx != want.vx) report_mismatch("vertex_x", got.vx, want.vx);
        if (got.vy != want.vy) report_mismatch("vertex_y", got.vy, want.vy);
        if (got.in_range != want.in_range)
          report_mismatch("in_range", got.in_range, want.in_range);
        if (got.has_tri != want.has_tri)
          report_mismatch("has_triangle", got.has_tri, want.has_tri);
        if (got.t1 != want.t1) report_mismatch("tri_first", got.t1, want.t1);
        if (got.t2 != want.t2) report_mismatch("tri_second", got.t2, want.t2);
        if (got.t3 != want.t3) report_mismatch("tri_third", got.t3, want.t3);
      end
    end
  end

  function automatic item_t rand_circle();
    item_t it;
    int cnt;
    it.center_x = $urandom;
    it.center_y = $urandom;
    case ($urandom_range(3))
      0: it.radius = $urandom_range(1310720);
      1: it.radius = -$urandom_range(1310720);
      2: it.radius = $urandom_range(40000000) - 20000000;
      default: it.radius = $urandom;
    endcase
    if ($urandom_range(3) == 0) begin
      it.center_x = $urandom_range(2000000) - 1000000;
      it.center_y = $urandom_range(2000000) - 1000000;
    end
    cnt = rim_count(it.radius);
    case ($urandom_range(9))
      0: it.vertex_number = $urandom;
      1: it.vertex_number = cnt[7:0];
      2: it.vertex_number = 8'd0;
      default: it.vertex_number = $urandom_range(cnt + 2 > 255 ? 255 : cnt + 2);
    endcase
    return it;
  endfunction

  dir_row_t dir_rows[$];

  function automatic dir_row_t mk(logic [31:0] cx, logic [31:0] cy, logic [31:0] r,
                                  logic [7:0] v, bit typed, vertex_t want);
    dir_row_t d;
    d.it = '{center_x: cx, center_y: cy, radius: r, vertex_number: v};
    d.typed = typed;
    d.want = want;
    return d;
  endfunction

  initial begin
    vertex_t none;
    vertex_t pv;
    none = '0;
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    // center vertex and out of range: values typed in
    dir_rows.push_back(mk(32'h0001_0000, 32'hFFFF_0000, 0, 0, 1,
                          '{8'd6, 32'h0001_0000, 32'hFFFF_0000, 1'b1, 1'b0, 0, 0, 0}));
    dir_rows.push_back(mk(32'h1234_5678, 32'h8765_4321, 0, 7, 1,
                          '{8'd6, 0, 0, 1'b0, 1'b0, 0, 0, 0}));
    dir_rows.push_back(mk(5, 6, 32'h7FFF_FFFF, 8'd255, 1,
                          '{8'd255, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 255, 0, 1}) );
    pv = predict_vertex(dir_rows[2].it);
    dir_rows[2].want.vx = pv.vx;
    dir_rows[2].want.vy = pv.vy;
    dir_rows.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 1,
                          '{8'd255, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 0, 0, 0}));
    dir_rows.push_back(mk(0, 0, 327680, 17, 1, '{8'd16, 0, 0, 1'b0, 1'b0, 0, 0, 0}));
    dir_rows.push_back(mk(0, 0, 327680, 16, 0, none));
    dir_rows.push_back(mk(0, 0, 327681, 18, 0, none));
    dir_rows.push_back(mk(0, 0, 327681, 1, 0, none));
    dir_rows.push_back(mk(0, 0, -327680, 5, 0, none));
    dir_rows.push_back(mk(0, 0, 32'hFFFF_FFFF, 6, 0, none));
    dir_rows.push_back(mk(0, 0, 65535, 1, 0, none));
    dir_rows.push_back(mk(0, 0, 65536, 8, 0, none));
    dir_rows.push_back(mk(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 1, 0, none));
    dir_rows.push_back(mk(32'h8000_0000, 0, 32'h7FFF_FFFF, 1, 0, none));
    dir_rows.push_back(mk(0, 32'h8000_0000, 32'h7FFF_FFFF, 65, 0, none));
    dir_rows.push_back(mk(0, 32'h7FFF_FFFF, 32'h8000_0000, 65, 0, none));
    dir_rows.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 128, 0, none));
    dir_rows.push_back(mk(32'h0A00_0000, 32'hF600_0000, 32'h0064_0000, 45, 0, none));
    dir_rows.push_back(mk(32'h0A00_0000, 32'hF600_0000, 32'hFF9C_0000, 46, 0, none));
    dir_rows.push_back(mk(32'h5555_5555, 32'hAAAA_AAAA, 32'h002A_0000, 31, 0, none));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) send_circle(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    for (int ph = 0; ph < 5; ph++) begin
      idle_pct  = (ph == 1) ? 82 : (ph == 3) ? 25 : 0;
      stall_pct = (ph == 2) ? 82 : (ph == 3) ? 25 : 0;
      if (ph == 4) hold_cycles = 300;
      repeat (375) send_circle(rand_circle(), 0, none);
    end
    s_tvalid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    while (vertex_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #30ms;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: circle_fan_vertex_generator.f
+incdir+rtl/core
rtl/core/cfvg_pkg.sv
rtl/core/cfvg_count.sv
rtl/core/cfvg_phase.sv
rtl/core/cfvg_pos.sv
rtl/core/circle_fan_vertex_generator.sv
rtl/core/cfvg_checker.sv
dv/tb_circle_fan_vertex_generator.sv
